/* src/next_fit_block_allocator_assert.svh */
// Assertion macros for the next-fit block allocator.
// Included by the top level; expects clk and rst in scope.
`ifndef NEXT_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define NEXT_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, masked during reset
`define NFBA_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset
`define NFBA_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/nfba_pkg.sv */
// Shared constants and types for the next-fit block allocator.
// No dependencies; used by nfba_cell and next_fit_block_allocator.
package nfba_pkg;

  localparam int NUM_BLOCKS = 8;
  localparam int SIZE_BITS  = 16;
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int IDX_W      = 3;
  localparam int CFG_W      = 4;
  localparam int RID_W      = 16;
  localparam int SUM_W      = 19;

  localparam logic [CFG_W-1:0] BC_RESET = CFG_W'(8);
  localparam logic [SUM_W-1:0] SUM_MAX  = '1;

  // Broadcast controls to every cell
  typedef struct packed {
    logic shift;    // token moves one cell on
    logic seed_en;  // token reloaded from seed vector
    logic grant;    // cell holding the token marks itself used
  } ctl_t;

  // Per-cell status, valid only at the token position
  typedef struct packed {
    logic                 tok;
    logic                 fit;
    logic                 free;
    logic [SIZE_BITS-1:0] size;
  } stat_t;

endpackage

/* src/next_fit_block_allocator.sv */
// Next-fit block allocator: a ring of slot cells scanned by a single token.
// Depends on nfba_pkg, nfba_cell and next_fit_block_allocator_assert.svh.
//
// Each item produces one result. A load writes the slot, then the token walks
// over the n active slots (n = active block count) and totals the free space,
// and then the result is registered. A request walks the token from the last
// granted slot one slot per cycle until a slot fits or all n are tried, then
// the free-space walk and the result register follow. The single token ring
// is shared by the search and the free-space total; one item is in work at a
// time, and the next one may be taken while a result waits.
`include "next_fit_block_allocator_assert.svh"

module next_fit_block_allocator (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [nfba_pkg::CFG_W-1:0]     cfg_data,
  // input items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           action,
  input  logic [nfba_pkg::IDX_W-1:0]     block_index,
  input  logic [15:0]                    size,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           granted,
  output logic [nfba_pkg::IDX_W-1:0]     granted_block,
  output logic [nfba_pkg::RID_W-1:0]     request_id,
  output logic [nfba_pkg::SIZE_BITS-1:0] leftover,
  output logic [nfba_pkg::SUM_W-1:0]     total_internal,
  output logic [nfba_pkg::SUM_W-1:0]     external_frag
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  localparam int NB  = nfba_pkg::NUM_BLOCKS;
  localparam int SB  = nfba_pkg::SIZE_BITS;
  localparam int BW  = nfba_pkg::BLK_W;
  localparam int CW  = nfba_pkg::CNT_W;
  localparam int SW  = nfba_pkg::SUM_W;

  state_t                 state;
  logic [nfba_pkg::CFG_W-1:0] block_count;
  logic [BW-1:0]          scan_start;
  logic [nfba_pkg::RID_W-1:0] request_counter;
  logic [SW-1:0]          internal_sum;
  logic [SW-1:0]          free_sum;
  logic                   any_failed;

  // per-item working registers
  logic [SB-1:0]          req_size;
  logic [BW-1:0]          k;
  logic [BW-1:0]          j;
  logic [SW-1:0]          acc;
  logic                   res_granted;
  logic [BW-1:0]          res_block;
  logic [SB-1:0]          res_left;
  logic [nfba_pkg::RID_W-1:0] res_rid;

  nfba_pkg::ctl_t         ctl;
  nfba_pkg::stat_t        stat [NB];
  logic [NB-1:0]          tok_vec;
  logic [NB-1:0]          tok_in;
  logic [NB-1:0]          seed_vec;
  logic [NB-1:0]          load_en;
  logic [BW-1:0]          seed_pos;

  logic                   accept;
  logic                   res_load;
  logic [CW-1:0]          n;
  logic                   last_k;
  logic [BW-1:0]          j0;
  logic [BW-1:0]          j_wrap;
  logic                   any_fit;
  logic                   sel_free;
  logic [SB-1:0]          sel_size;
  logic [SB-1:0]          left_calc;
  logic [SW:0]            int_wide;
  logic [SW-1:0]          int_sat;
  logic [SW:0]            acc_wide;
  logic [SW-1:0]          acc_sat;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  // result register takes a new item when empty or being emptied
  assign res_load = (state == ST_DONE) && (!out_valid || !out_stall);

  // Active block count: zero counts as one, clamp at the ring length
  always_comb begin
    if (block_count == '0) begin
      n = CW'(1);
    end else if (32'(block_count) > NB) begin
      n = CW'(NB);
    end else begin
      n = CW'(block_count);
    end
  end

  assign last_k = (CW'(k) == n - CW'(1));
  assign j0     = (CW'(scan_start) < n) ? scan_start : '0;
  assign j_wrap = (CW'(j) + CW'(1) == n) ? '0 : j + BW'(1);

  // Collect the status of the slot under the token
  always_comb begin
    any_fit  = 1'b0;
    sel_free = 1'b0;
    sel_size = '0;
    for (int i = 0; i < NB; i++) begin
      any_fit    = any_fit  | stat[i].fit;
      sel_free   = sel_free | stat[i].free;
      sel_size   = sel_size | stat[i].size;
      tok_vec[i] = stat[i].tok;
    end
  end

  // Saturating sums
  assign left_calc = sel_size - req_size;
  assign int_wide  = {1'b0, internal_sum} + (SW+1)'(left_calc);
  assign int_sat   = int_wide[SW] ? nfba_pkg::SUM_MAX : int_wide[SW-1:0];
  assign acc_wide  = {1'b0, acc} + (SW+1)'(sel_free ? sel_size : '0);
  assign acc_sat   = acc_wide[SW] ? nfba_pkg::SUM_MAX : acc_wide[SW-1:0];

  // Token ring: the last active slot hands back to slot 0
  always_comb begin
    tok_in[0] = 1'b0;
    for (int i = 0; i < NB; i++) begin
      if (CW'(i) == n - CW'(1)) begin
        tok_in[0] = tok_in[0] | tok_vec[i];
      end
    end
    for (int i = 1; i < NB; i++) begin
      tok_in[i] = tok_vec[i-1] && (CW'(i) != n);
    end
  end

  // Seed position and load strobes
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      seed_vec[i] = (BW'(i) == seed_pos);
      load_en[i]  = accept && !action &&
                    ((BW+nfba_pkg::IDX_W)'(block_index) == (BW+nfba_pkg::IDX_W)'(i));
    end
  end

  // Cell controls
  always_comb begin
    ctl      = '0;
    seed_pos = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ctl.seed_en = 1'b1;
          seed_pos    = action ? j0 : '0;
        end
      end
      ST_SCAN: begin
        if (any_fit) begin
          ctl.grant   = 1'b1;
          ctl.seed_en = 1'b1;
        end else if (last_k) begin
          ctl.seed_en = 1'b1;
        end else begin
          ctl.shift = 1'b1;
        end
      end
      ST_SUM:  ctl.shift = !last_k;
      ST_DONE: ctl = '0;
      default: ctl = '0;
    endcase
  end

  // Slot ring
  for (genvar g = 0; g < NB; g++) begin : g_cell
    nfba_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .seed      (seed_vec[g]),
      .tok_in    (tok_in[g]),
      .load_en   (load_en[g]),
      .load_size (size[SB-1:0]),
      .req_size  (req_size),
      .stat      (stat[g])
    );
  end

  // Sequencer and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      block_count     <= nfba_pkg::BC_RESET;
      scan_start      <= '0;
      request_counter <= '0;
      internal_sum    <= '0;
      free_sum        <= '0;
      any_failed      <= 1'b0;
      out_valid       <= 1'b0;
      k               <= '0;
    end else begin
      if (cfg_we) begin
        block_count <= cfg_data;
      end
      // result handshake
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            k           <= '0;
            acc         <= '0;
            req_size    <= size[SB-1:0];
            res_granted <= 1'b0;
            res_block   <= '0;
            res_left    <= '0;
            res_rid     <= '0;
            if (action) begin
              res_rid         <= request_counter;
              request_counter <= request_counter + 1'b1;
              j               <= j0;
              state           <= ST_SCAN;
            end else begin
              state <= ST_SUM;
            end
          end
        end
        ST_SCAN: begin
          if (any_fit) begin
            res_granted  <= 1'b1;
            res_block    <= j;
            res_left     <= left_calc;
            internal_sum <= int_sat;
            scan_start   <= j;
            k            <= '0;
            state        <= ST_SUM;
          end else if (last_k) begin
            any_failed <= 1'b1;
            k          <= '0;
            state      <= ST_SUM;
          end else begin
            k <= k + BW'(1);
            j <= j_wrap;
          end
        end
        ST_SUM: begin
          acc <= acc_sat;
          if (last_k) begin
            free_sum <= acc_sat;
            state    <= ST_DONE;
          end else begin
            k <= k + BW'(1);
          end
        end
        ST_DONE: begin
          if (res_load) begin
            granted        <= res_granted;
            granted_block  <= nfba_pkg::IDX_W'(res_block);
            request_id     <= res_rid;
            leftover       <= res_left;
            total_internal <= internal_sum;
            external_frag  <= any_failed ? free_sum : '0;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `NFBA_HOLDS(a_one_token, (state == ST_SCAN) || (state == ST_SUM), $onehot(tok_vec), "token ring lost its token")
  `NFBA_HOLDS(a_walk_bound, (state == ST_SCAN) || (state == ST_SUM), CW'(k) < n, "walk ran past active slots")
  `NFBA_HOLDS(a_nogrant_clean, out_valid && !granted, (leftover == '0) && (granted_block == '0), "refused item carries grant data")
  `NFBA_NEXT(a_result_held, (state == ST_DONE) && out_valid && out_stall, state == ST_DONE, "result dropped while stalled")

endmodule

/* src/nfba_cell.sv */
// One block slot of the allocator ring: size, used bit and scan token.
// Depends on nfba_pkg.
module nfba_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  nfba_pkg::ctl_t                 ctl,
  input  logic                           seed,
  input  logic                           tok_in,
  input  logic                           load_en,
  input  logic [nfba_pkg::SIZE_BITS-1:0] load_size,
  input  logic [nfba_pkg::SIZE_BITS-1:0] req_size,
  output nfba_pkg::stat_t                stat
);

  logic [nfba_pkg::SIZE_BITS-1:0] blk_size;
  logic                           used;
  logic                           tok;

  // Slot contents and token
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_size <= '0;
      used     <= 1'b0;
      tok      <= 1'b0;
    end else begin
      if (load_en) begin
        blk_size <= load_size;
        used     <= 1'b0;
      end else if (ctl.grant && tok) begin
        used <= 1'b1;
      end
      if (ctl.seed_en) begin
        tok <= seed;
      end else if (ctl.shift) begin
        tok <= tok_in;
      end
    end
  end

  // Status is gated by the token so the top can OR all cells together
  always_comb begin
    stat.tok  = tok;
    stat.free = tok && !used;
    stat.fit  = tok && !used && (blk_size >= req_size);
    stat.size = tok ? blk_size : '0;
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the next-fit block allocator: directed table, random phases.
// Depends on nfba_pkg and the next_fit_block_allocator RTL; needs no files or arguments.

module tb_top;

  localparam int NUM_BLOCKS = nfba_pkg::NUM_BLOCKS;
  localparam int SIZE_BITS  = nfba_pkg::SIZE_BITS;
  localparam int IDX_W      = nfba_pkg::IDX_W;
  localparam int CFG_W      = nfba_pkg::CFG_W;
  localparam int RID_W      = nfba_pkg::RID_W;
  localparam int SUM_W      = nfba_pkg::SUM_W;
  localparam logic [SUM_W-1:0] SUM_MAX  = nfba_pkg::SUM_MAX;
  localparam logic [CFG_W-1:0] BC_RESET = nfba_pkg::BC_RESET;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 2 * NUM_BLOCKS + 8;
  localparam int FAST_ITEMS    = 40;

  typedef enum bit {ACT_LOAD = 1'b0, ACT_REQUEST = 1'b1} action_t;

  typedef struct packed {
    logic                 granted;
    logic [IDX_W-1:0]     blk;
    logic [RID_W-1:0]     rid;
    logic [SIZE_BITS-1:0] left;
    logic [SUM_W-1:0]     tot;
    logic [SUM_W-1:0]     ext;
  } alloc_res_t;

  typedef struct packed {
    action_t          act;
    logic [IDX_W-1:0] idx;
    logic [15:0]      sz;
    bit               typed;
    alloc_res_t       exp_res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 action;
  logic [IDX_W-1:0]     block_index;
  logic [15:0]          size;
  logic                 out_valid;
  logic                 out_stall;
  logic                 granted;
  logic [IDX_W-1:0]     granted_block;
  logic [RID_W-1:0]     request_id;
  logic [SIZE_BITS-1:0] leftover;
  logic [SUM_W-1:0]     total_internal;
  logic [SUM_W-1:0]     external_frag;

  next_fit_block_allocator DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .block_index    (block_index),
    .size           (size),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .granted        (granted),
    .granted_block  (granted_block),
    .request_id     (request_id),
    .leftover       (leftover),
    .total_internal (total_internal),
    .external_frag  (external_frag)
  );

  always #5 clk = ~clk;

  // Allocator state as the testbench tracks it
  logic [SIZE_BITS-1:0] blk_size [NUM_BLOCKS];
  bit                   blk_used [NUM_BLOCKS];
  int                   scan_from;
  int unsigned          int_sum;
  logic [RID_W-1:0]     req_count;
  bit                   any_failed;
  logic [CFG_W-1:0]     count_reg;

  alloc_res_t alloc_results_q[$];

  int  n_items, n_loads, n_grants, n_fails, n_results, n_cfg, errors;
  int  burst_left, holds_asked;
  bit  fast_mode;

  // Directed items: typed results only where they are obvious
  dir_row_t dir_rows[$] = '{
    // request for size 0 before any load: unloaded block 0 fits
    '{ACT_REQUEST, 3'd0, 16'd0,     1'b1, '{1'b1, 3'd0, 16'd0, 16'd0, 19'd0, 19'd0}},
    // load every block, extremes included; reload of block 0 frees it
    '{ACT_LOAD,    3'd0, 16'hFFFF,  1'b1, '0},
    '{ACT_LOAD,    3'd1, 16'd100,   1'b1, '0},
    '{ACT_LOAD,    3'd2, 16'd0,     1'b1, '0},
    '{ACT_LOAD,    3'd3, 16'd50,    1'b1, '0},
    '{ACT_LOAD,    3'd4, 16'd200,   1'b1, '0},
    '{ACT_LOAD,    3'd5, 16'hFFFF,  1'b1, '0},
    '{ACT_LOAD,    3'd6, 16'd1,     1'b1, '0},
    '{ACT_LOAD,    3'd7, 16'd300,   1'b1, '0},
    // exact fit of the largest size in block 0
    '{ACT_REQUEST, 3'd7, 16'hFFFF,  1'b1, '{1'b1, 3'd0, 16'd1, 16'd0, 19'd0, 19'd0}},
    '{ACT_REQUEST, 3'd5, 16'd60,    1'b0, '0},
    '{ACT_REQUEST, 3'd2, 16'd0,     1'b0, '0},
    '{ACT_REQUEST, 3'd0, 16'd250,   1'b0, '0},
    // nothing big enough left: first failure, external figure starts
    '{ACT_REQUEST, 3'd7, 16'hFFFF,  1'b0, '0},
    '{ACT_REQUEST, 3'd1, 16'd1,     1'b0, '0},
    '{ACT_REQUEST, 3'd6, 16'd1,     1'b0, '0},
    // wraps past the end of the ring
    '{ACT_REQUEST, 3'd3, 16'd200,   1'b0, '0},
    '{ACT_REQUEST, 3'd4, 16'd0,     1'b0, '0},
    // every block used
    '{ACT_REQUEST, 3'd0, 16'd0,     1'b0, '0},
    '{ACT_LOAD,    3'd3, 16'hFFFF,  1'b0, '0},
    '{ACT_REQUEST, 3'd7, 16'hFFFF,  1'b0, '0},
    '{ACT_LOAD,    3'd6, 16'h5555,  1'b0, '0},
    '{ACT_REQUEST, 3'd2, 16'hAAAA,  1'b0, '0},
    '{ACT_REQUEST, 3'd5, 16'h5555,  1'b0, '0}
  };

  // Block count as used by the search
  function automatic int active_blocks();
    if (count_reg == 0) return 1;
    if (count_reg > NUM_BLOCKS) return NUM_BLOCKS;
    return int'(count_reg);
  endfunction

  // Next-fit search and fragmentation bookkeeping for one item
  function automatic alloc_res_t allocate_next_fit(action_t act, logic [IDX_W-1:0] idx,
                                                   logic [15:0] sz);
    alloc_res_t           r;
    int                   n, j;
    longint unsigned      acc;
    logic [SIZE_BITS-1:0] want;
    r    = '0;
    want = sz[SIZE_BITS-1:0];
    n    = active_blocks();
    if (act == ACT_LOAD) begin
      if (idx < NUM_BLOCKS) begin
        blk_size[idx] = want;
        blk_used[idx] = 1'b0;
      end
      n_loads++;
    end else begin
      // stale start point falls back to block 0
      j     = (scan_from < n) ? scan_from : 0;
      r.rid = req_count;
      req_count++;
      for (int k = 0; k < n; k++) begin
        if (!blk_used[j] && blk_size[j] >= want) begin
          r.granted   = 1'b1;
          r.blk       = IDX_W'(j);
          r.left      = blk_size[j] - want;
          blk_used[j] = 1'b1;
          scan_from   = j;
          acc         = longint'(int_sum) + r.left;
          int_sum     = (acc > SUM_MAX) ? int'(SUM_MAX) : int'(acc);
          break;
        end
        j = (j + 1 == n) ? 0 : j + 1;
      end
      if (r.granted) n_grants++;
      else begin
        any_failed = 1'b1;
        n_fails++;
      end
    end
    // free space over the searched blocks, after this item
    acc = 0;
    for (int i = 0; i < n; i++)
      if (!blk_used[i]) acc += blk_size[i];
    if (acc > SUM_MAX) acc = SUM_MAX;
    r.tot = SUM_W'(int_sum);
    r.ext = any_failed ? SUM_W'(acc) : '0;
    return r;
  endfunction

  function automatic logic [15:0] pick_size(bit for_load);
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, for_load ? 1000 : 400));
    endcase
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Offer one item, hold it until taken, then record its expected result
  task automatic send_item(action_t act, logic [IDX_W-1:0] idx, logic [15:0] sz,
                           bit typed, alloc_res_t typed_res);
    alloc_res_t r;
    @(negedge clk);
    in_valid    <= 1'b1;
    action      <= act;
    block_index <= idx;
    size        <= sz;
    do @(posedge clk); while (in_stall);
    r = allocate_next_fit(act, idx, sz);
    alloc_results_q.push_back(typed ? typed_res : r);
    n_items++;
  endtask

  // Bursts of random length, random gaps with junk on the payload
  task automatic pace_sender();
    int g;
    if (fast_mode) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    g = $urandom_range(1, 9);
    repeat (g) begin
      @(negedge clk);
      in_valid    <= 1'b0;
      action      <= 1'($urandom);
      block_index <= IDX_W'($urandom);
      size        <= 16'($urandom);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (alloc_results_q.size() != 0) @(posedge clk);
  endtask

  // Block count only changes while the allocator is idle
  task automatic write_count(logic [CFG_W-1:0] v);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    count_reg = v;
    n_cfg++;
  endtask

  // One block-count setting: load the active blocks, then mixed random traffic
  task automatic run_phase(logic [CFG_W-1:0] cnt, int items, bit big_start, bit hold,
                           bit pause);
    int n, pick;
    write_count(cnt);
    n = active_blocks();
    for (int i = 0; i < n; i++) begin
      send_item(ACT_LOAD, IDX_W'(i), big_start ? 16'hFFFF : pick_size(1'b1), 1'b0, '0);
      pace_sender();
    end
    // largest leftovers: drives the internal total into saturation
    if (big_start)
      for (int i = 0; i < n; i++) begin
        send_item(ACT_REQUEST, IDX_W'($urandom), 16'd0, 1'b0, '0);
        pace_sender();
      end
    for (int i = 0; i < items; i++) begin
      if (hold && i == items / 3) begin
        holds_asked++;
        burst_left = 40;
      end
      if (pause && i == 2 * items / 3) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 5)
        send_item(ACT_LOAD, IDX_W'($urandom), pick_size(1'b1), 1'b0, '0);
      else if (pick < 25)
        send_item(ACT_LOAD, IDX_W'($urandom_range(0, n - 1)), pick_size(1'b1), 1'b0, '0);
      else
        send_item(ACT_REQUEST, IDX_W'($urandom), pick_size(1'b0), 1'b0, '0);
      pace_sender();
    end
  endtask

  // Receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int stall_left, open_left, holds_done;
    stall_left = 0;
    open_left  = 0;
    holds_done = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (fast_mode) begin
        out_stall <= 1'b0;
      end else begin
        if (stall_left == 0 && open_left == 0) begin
          stall_left = $urandom_range(0, 4);
          open_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 6);
        end
        if (stall_left > 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end else begin
          out_stall <= 1'b0;
          open_left--;
        end
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    alloc_res_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (alloc_results_q.size() == 0) begin
        note_error("result with nothing outstanding");
      end else begin
        want = alloc_results_q.pop_front();
        if (granted !== want.granted || granted_block !== want.blk ||
            request_id !== want.rid || leftover !== want.left ||
            total_internal !== want.tot || external_frag !== want.ext)
          note_error($sformatf({"mismatch: exp g=%0d blk=%0d rid=%0d left=%0d tot=%0d ",
                                "ext=%0d, got g=%0d blk=%0d rid=%0d left=%0d tot=%0d ext=%0d"},
                               want.granted, want.blk, want.rid, want.left, want.tot,
                               want.ext, granted, granted_block, request_id, leftover,
                               total_internal, external_frag));
      end
    end
  end

  // Watchdog
  initial begin
    #(20_000_000);
    $display("tb_top: errors");
    $finish;
  end

  // Main sequence
  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_data    = BC_RESET;
    in_valid    = 1'b0;
    action      = 1'b0;
    block_index = '0;
    size        = '0;
    foreach (blk_size[i]) begin
      blk_size[i] = '0;
      blk_used[i] = 1'b0;
    end
    scan_from   = 0;
    int_sum     = 0;
    req_count   = '0;
    any_failed  = 1'b0;
    count_reg   = BC_RESET;
    fast_mode   = 1'b0;
    burst_left  = 0;
    holds_asked = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table at the reset block count
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].act, dir_rows[i].idx, dir_rows[i].sz, dir_rows[i].typed,
                dir_rows[i].exp_res);
      pace_sender();
    end

    // random phases across block-count settings, extremes first
    run_phase(4'd1,  70, 1'b0, 1'b0, 1'b0);
    run_phase(4'd15, 90, 1'b1, 1'b1, 1'b0);
    run_phase(4'd0,  60, 1'b0, 1'b0, 1'b1);
    run_phase(4'd8,  60, 1'b0, 1'b0, 1'b0);
    run_phase(4'd3,  80, 1'b0, 1'b0, 1'b0);
    run_phase(4'd9,  80, 1'b0, 1'b0, 1'b0);
    run_phase(4'd5,  80, 1'b0, 1'b1, 1'b1);

    // back-to-back items on one block with the receiver wide open
    write_count(4'd1);
    fast_mode = 1'b1;
    for (int i = 0; i < FAST_ITEMS; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_item(ACT_LOAD, '0, 16'($urandom), 1'b0, '0);
      else
        send_item(ACT_REQUEST, IDX_W'($urandom), 16'($urandom_range(0, 2000)), 1'b0, '0);
    end
    fast_mode = 1'b0;

    run_phase(4'd2,  60, 1'b0, 1'b0, 1'b0);
    run_phase(4'd8,  50, 1'b0, 1'b0, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb_top: %0d items sent (%0d loads), %0d grants, %0d refusals, %0d results seen",
             n_items, n_loads, n_grants, n_fails, n_results);
    $display("tb_top: %0d block-count writes, request number now %0d, %0d mismatches",
             n_cfg, req_count, errors);
    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

/* next_fit_block_allocator.f */
+incdir+src
src/nfba_pkg.sv
src/nfba_cell.sv
src/next_fit_block_allocator.sv
tb/tb_top.sv
